### rtl/core/potfs_pkg.sv
// Shared types and constants for the priority oldest-first task scheduler.
`default_nettype none

package potfs_pkg;

  localparam int MAX_TASKS       = 16;
  localparam int PRIORITY_LEVELS = 32;
  localparam int EVENT_BITS      = 64;

  localparam int FUNC_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int LEVEL_W = 5;
  localparam int EV_W    = 6;
  localparam int TIME_W  = 32;
  localparam int TASK_W  = SLOT_W + 1;

  localparam logic [TASK_W-1:0] IDLE_CODE = TASK_W'(MAX_TASKS);

  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CREATE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_BLOCK  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIRE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_EXIT   = 3'd5;

  localparam logic [1:0] TS_STOPPED = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_BLOCKED = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [SLOT_W-1:0]  task_slot;
    logic [LEVEL_W-1:0] priority_req;
    logic [EV_W-1:0]    event_id;
  } in_t;

  typedef struct packed {
    logic [TASK_W-1:0] pick_slot;
    logic              switch_needed;
  } out_t;

  // One task table entry held in RAM.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  served;
    logic [EV_W-1:0]    wait_ev;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BLK_WR,
    S_SCAN,
    S_FINISH
  } sched_state_t;

endpackage

`default_nettype wire

### rtl/core/priority_oldest_first_task_scheduler_core.sv
// Top level of the priority oldest-first task scheduler.
//
// Input channel (in_valid / in_stall / in_data) carries one command per
// transaction: tick, create, block current, fire event, clear event, exit.
// Only a tick produces a result on the output channel (out_valid /
// out_stall / out_data): the chosen slot (16 = idle) and a switch flag.
// Create, fire, clear and exit complete on acceptance; block reads the
// running task's RAM entry and then writes it back.
// A tick starts, makes one pass over the task table RAM (one entry per
// cycle through its single read port, which wakes, stamps and compares in
// the same pass) and then commits. Its result is valid the cycle after
// commit. One command is in flight at a time.
// A finished tick result sits in an output register; if out_stall holds
// it there when the next tick finishes, that tick waits in commit.
// Synchronous reset clears task valid and status bits, event flags, the
// time counter and the output valid flag, and sets the running task to idle.
// The per-task RAM fields are written by create before they are ever used.
`default_nettype none

module priority_oldest_first_task_scheduler_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire potfs_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output potfs_pkg::out_t      out_data
);

  localparam int NT = potfs_pkg::MAX_TASKS;
  localparam int SW = potfs_pkg::SLOT_W;

  potfs_pkg::sched_state_t state_r, state_nxt;

  logic [SW-1:0]                  idx_r, idx_nxt;
  logic [potfs_pkg::TIME_W-1:0]   time_r, time_nxt;
  logic [potfs_pkg::TASK_W-1:0]   run_r, run_nxt;
  logic [potfs_pkg::TASK_W-1:0]   pick_r, pick_nxt;
  logic [potfs_pkg::LEVEL_W-1:0]  best_lvl_r, best_lvl_nxt;
  logic [potfs_pkg::TIME_W-1:0]   best_age_r, best_age_nxt;
  logic [potfs_pkg::EV_W-1:0]     ev_r, ev_nxt;
  logic [potfs_pkg::EVENT_BITS-1:0] flags_r, flags_nxt;
  logic [NT-1:0]                  valid_r, valid_nxt;
  logic [1:0]                     status_r [NT];
  logic [1:0]                     status_nxt [NT];
  logic                           out_valid_r, out_valid_nxt;
  potfs_pkg::out_t                out_r, out_nxt;

  logic                   ram_we;
  logic [SW-1:0]          ram_wr_addr;
  potfs_pkg::entry_t      ram_wr_data;
  logic                   ram_rd_en;
  logic [SW-1:0]          ram_rd_addr;
  potfs_pkg::entry_t      ram_rd_data;

  logic                   acc;
  logic                   live;
  logic                   ev_ok;
  logic                   create_ok;
  logic                   out_free;
  logic                   last_idx;
  logic                   stamp;
  logic                   woke;
  logic                   rdy;
  logic                   take;
  logic [potfs_pkg::TIME_W-1:0] served_eff;
  logic [potfs_pkg::TIME_W-1:0] age;

  potfs_ram #(
    .WIDTH ($bits(potfs_pkg::entry_t)),
    .DEPTH (NT)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != potfs_pkg::S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_idx  = (idx_r == SW'(NT - 1));

  assign live      = !run_r[SW] && valid_r[run_r[SW-1:0]];
  assign ev_ok     = ({1'b0, in_data.event_id} < (potfs_pkg::EV_W + 1)'(potfs_pkg::EVENT_BITS));
  assign create_ok = ({1'b0, in_data.task_slot} < (SW + 1)'(NT)) &&
                     ({1'b0, in_data.priority_req} <
                      (potfs_pkg::LEVEL_W + 1)'(potfs_pkg::PRIORITY_LEVELS));

  // Scan datapath for the entry whose RAM data is on the read port.
  assign stamp      = !run_r[SW] && (run_r[SW-1:0] == idx_r);
  assign served_eff = stamp ? time_r : ram_rd_data.served;
  assign age        = time_r - served_eff;
  assign woke       = valid_r[idx_r] && (status_r[idx_r] == potfs_pkg::TS_BLOCKED) &&
                      flags_r[ram_rd_data.wait_ev];
  assign rdy        = valid_r[idx_r] && ((status_r[idx_r] == potfs_pkg::TS_READY) || woke);
  assign take       = rdy && (pick_r[SW] || (ram_rd_data.level < best_lvl_r) ||
                      ((ram_rd_data.level == best_lvl_r) && (age > best_age_r)));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      potfs_pkg::S_IDLE: begin
        if (acc) begin
          if (in_data.func == potfs_pkg::FN_TICK) begin
            state_nxt = potfs_pkg::S_SCAN;
          end else if ((in_data.func == potfs_pkg::FN_BLOCK) && live && ev_ok) begin
            state_nxt = potfs_pkg::S_BLK_WR;
          end
        end
      end
      potfs_pkg::S_BLK_WR: state_nxt = potfs_pkg::S_IDLE;
      potfs_pkg::S_SCAN: begin
        if (last_idx) begin
          state_nxt = potfs_pkg::S_FINISH;
        end
      end
      potfs_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = potfs_pkg::S_IDLE;
        end
      end
      default: state_nxt = potfs_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM control and outputs.
  always_comb begin
    idx_nxt       = idx_r;
    time_nxt      = time_r;
    run_nxt       = run_r;
    pick_nxt      = pick_r;
    best_lvl_nxt  = best_lvl_r;
    best_age_nxt  = best_age_r;
    ev_nxt        = ev_r;
    flags_nxt     = flags_r;
    valid_nxt     = valid_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_wr_addr   = idx_r;
    ram_wr_data   = ram_rd_data;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_r + SW'(1);

    unique case (state_r)
      potfs_pkg::S_IDLE: begin
        if (acc) begin
          case (in_data.func)
            potfs_pkg::FN_TICK: begin
              time_nxt    = time_r + potfs_pkg::TIME_W'(1);
              idx_nxt     = '0;
              pick_nxt    = potfs_pkg::IDLE_CODE;
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
            end
            potfs_pkg::FN_CREATE: begin
              if (create_ok) begin
                valid_nxt[in_data.task_slot]  = 1'b1;
                status_nxt[in_data.task_slot] = potfs_pkg::TS_READY;
                ram_we              = 1'b1;
                ram_wr_addr         = in_data.task_slot;
                ram_wr_data.level   = in_data.priority_req;
                ram_wr_data.served  = '0;
                ram_wr_data.wait_ev = '0;
              end
            end
            potfs_pkg::FN_BLOCK: begin
              if (live && ev_ok) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = run_r[SW-1:0];
                ev_nxt      = in_data.event_id;
              end
            end
            potfs_pkg::FN_FIRE: begin
              if (ev_ok) begin
                flags_nxt[in_data.event_id] = 1'b1;
              end
            end
            potfs_pkg::FN_CLEAR: begin
              if (ev_ok) begin
                flags_nxt[in_data.event_id] = 1'b0;
              end
            end
            potfs_pkg::FN_EXIT: begin
              if (live) begin
                valid_nxt[run_r[SW-1:0]]  = 1'b0;
                status_nxt[run_r[SW-1:0]] = potfs_pkg::TS_STOPPED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      potfs_pkg::S_BLK_WR: begin
        // Write back the running entry with its new wait event.
        ram_we              = 1'b1;
        ram_wr_addr         = run_r[SW-1:0];
        ram_wr_data.wait_ev = ev_r;
        status_nxt[run_r[SW-1:0]] = potfs_pkg::TS_BLOCKED;
      end
      potfs_pkg::S_SCAN: begin
        ram_rd_en = !last_idx;
        idx_nxt   = idx_r + SW'(1);
        if (stamp) begin
          ram_we             = 1'b1;
          ram_wr_addr        = idx_r;
          ram_wr_data.served = time_r;
        end
        if (woke) begin
          status_nxt[idx_r] = potfs_pkg::TS_READY;
        end
        if (take) begin
          pick_nxt     = {1'b0, idx_r};
          best_lvl_nxt = ram_rd_data.level;
          best_age_nxt = age;
        end
      end
      potfs_pkg::S_FINISH: begin
        if (out_free) begin
          run_nxt               = pick_r;
          out_valid_nxt         = 1'b1;
          out_nxt.pick_slot     = pick_r;
          out_nxt.switch_needed = (pick_r != run_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= potfs_pkg::S_IDLE;
      time_r      <= '0;
      run_r       <= potfs_pkg::IDLE_CODE;
      flags_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        status_r[i] <= potfs_pkg::TS_STOPPED;
      end
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      run_r       <= run_nxt;
      flags_r     <= flags_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pick_r     <= pick_nxt;
    best_lvl_r <= best_lvl_nxt;
    best_age_r <= best_age_nxt;
    ev_r       <= ev_nxt;
    out_r      <= out_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/potfs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module potfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
